// File: design/wec_pkg.sv
// Shared constants, types and helpers for the wheel encoder edge counter.
package wec_pkg;

  // Window and field sizes
  localparam int WindowDepth = 4;
  localparam int SampleBits  = 10;
  localparam int ThreshBits  = 10;
  localparam int CountBits   = 16;
  localparam int DepthBits   = $clog2(WindowDepth);
  localparam int SumBits     = SampleBits + DepthBits;
  localparam int LimBits     = ThreshBits + 1 + DepthBits;
  localparam int CmpBits     = (SumBits > LimBits) ? SumBits : LimBits;

  // Configuration port
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = ThreshBits;
  localparam logic [CfgIdxBits-1:0] CfgUpperIdx = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgLowerIdx = 1'b1;

  localparam logic [ThreshBits-1:0] UpperReset = 10'd480;
  localparam logic [ThreshBits-1:0] LowerReset = 10'd470;

  // Request function codes
  localparam logic FuncSample = 1'b0;
  localparam logic FuncClear  = 1'b1;

  // Area classes
  localparam logic AreaDark  = 1'b0;
  localparam logic AreaLight = 1'b1;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [ThreshBits-1:0] thresh_t;
  typedef logic [CmpBits-1:0]    cmp_t;

  // Thresholds scaled to the window sum
  typedef struct packed {
    cmp_t upper_lim;  // sum at or above this: average above upper threshold
    cmp_t lower_lim;  // sum below this: average below lower threshold
  } wec_limits_t;

  // Per-side update strobes
  typedef struct packed {
    logic load;
    logic clear;
  } wec_side_ctrl_t;

  // floor(sum / depth) > t  <=>  sum >= (t + 1) * depth
  function automatic cmp_t scale_upper(thresh_t t);
    cmp_t base;
    base = cmp_t'(t) + cmp_t'(1);
    return base * cmp_t'(WindowDepth);
  endfunction

  // floor(sum / depth) < t  <=>  sum < t * depth
  function automatic cmp_t scale_lower(thresh_t t);
    return cmp_t'(t) * cmp_t'(WindowDepth);
  endfunction

endpackage

// File: design/wec_if.sv
// Sample request and result channel interfaces.
interface wec_smp_if;
  logic              valid;
  logic              ready;
  logic              func;
  wec_pkg::sample_t  left_sample;
  wec_pkg::sample_t  right_sample;

  modport source (output valid, func, left_sample, right_sample, input ready);
  modport sink   (input valid, func, left_sample, right_sample, output ready);
endinterface

interface wec_res_if;
  logic             valid;
  logic             ready;
  wec_pkg::count_t  left_count;
  wec_pkg::count_t  right_count;
  logic             left_area;
  logic             right_area;

  modport source (output valid, left_count, right_count, left_area, right_area,
                  input ready);
  modport sink   (input valid, left_count, right_count, left_area, right_area,
                  output ready);
endinterface

// File: design/wheel_encoder_edge_counter_core.sv
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the output register takes a new result
// in the same cycle the previous one is taken.
// Reset clears the history cells, window sums, classes (dark) and tick counts
// and loads the default thresholds; no clearing pass, requests accepted at once.
module wheel_encoder_edge_counter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wec_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [wec_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  wec_smp_if.sink                             in_if,
  wec_res_if.source                           out_if
);

  wec_pkg::wec_limits_t   limits_q, limits_d;
  wec_pkg::wec_side_ctrl_t side_ctrl;
  wec_pkg::count_t        left_cnt_nxt, right_cnt_nxt;
  logic                   left_area_nxt, right_area_nxt;
  logic                   in_accept;
  logic                   out_valid_q, out_valid_d;

  // Store thresholds already scaled to the window sum
  always_comb begin
    limits_d = limits_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wec_pkg::CfgUpperIdx: limits_d.upper_lim = wec_pkg::scale_upper(cfg_wdata_i);
        wec_pkg::CfgLowerIdx: limits_d.lower_lim = wec_pkg::scale_lower(cfg_wdata_i);
        default:              limits_d = limits_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.upper_lim <= wec_pkg::scale_upper(wec_pkg::UpperReset);
      limits_q.lower_lim <= wec_pkg::scale_lower(wec_pkg::LowerReset);
    end else begin
      limits_q <= limits_d;
    end
  end

  // Accept a request whenever the output register is free or being drained
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;

  assign side_ctrl.load  = in_accept && (in_if.func == wec_pkg::FuncSample);
  assign side_ctrl.clear = in_accept && (in_if.func == wec_pkg::FuncClear);

  wec_side u_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (side_ctrl),
    .sample_i    (in_if.left_sample),
    .limits_i    (limits_q),
    .count_nxt_o (left_cnt_nxt),
    .area_nxt_o  (left_area_nxt)
  );

  wec_side u_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (side_ctrl),
    .sample_i    (in_if.right_sample),
    .limits_i    (limits_q),
    .count_nxt_o (right_cnt_nxt),
    .area_nxt_o  (right_area_nxt)
  );

  // Output register: fill on accept, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_if.left_count  <= left_cnt_nxt;
      out_if.right_count <= right_cnt_nxt;
      out_if.left_area   <= left_area_nxt;
      out_if.right_area  <= right_area_nxt;
    end
  end

  assign out_if.valid = out_valid_q;

  // A clear request reports zero counts
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_ctrl.clear |=> (out_if.left_count == '0) && (out_if.right_count == '0))
    else $error("clear request did not report zero counts");

  // Every accepted request shows up as a pending result
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_if.valid)
    else $error("accepted request produced no result");

  // A stalled result blocks new requests
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("request accepted over a stalled result");

  // Load and clear strobes never fire together
  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(side_ctrl.load && side_ctrl.clear))
    else $error("load and clear strobes both active");

endmodule

// File: design/wec_tap_cell.sv
// One history cell: holds a sample and passes it to the next cell on load.
module wec_tap_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  wec_pkg::sample_t d_i,
  output wec_pkg::sample_t q_o
);

  wec_pkg::sample_t tap_q;
  wec_pkg::sample_t tap_d;

  // Take the neighbor's sample on a shift, hold otherwise
  assign tap_d = shift_i ? d_i : tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  assign q_o = tap_q;

endmodule

// File: design/wec_side.sv
// One side: history cell chain, running window sum, Schmitt trigger, tick counter.
module wec_side (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wec_pkg::wec_side_ctrl_t ctrl_i,
  input  wec_pkg::sample_t       sample_i,
  input  wec_pkg::wec_limits_t   limits_i,
  output wec_pkg::count_t        count_nxt_o,
  output logic                   area_nxt_o
);

  wec_pkg::sample_t taps [wec_pkg::WindowDepth];

  logic [wec_pkg::SumBits-1:0] sum_q, sum_d;
  logic [wec_pkg::SumBits:0]   sum_wide;
  wec_pkg::cmp_t               sum_cmp;
  wec_pkg::count_t             count_q, count_d;
  logic                        area_q, area_d, area_cls;

  // Chain of history cells, newest at the head
  for (genvar k = 0; k < wec_pkg::WindowDepth; k++) begin : g_tap
    wec_pkg::sample_t tap_in;
    if (k == 0) begin : g_head
      assign tap_in = sample_i;
    end else begin : g_link
      assign tap_in = taps[k-1];
    end
    wec_tap_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctrl_i.load),
      .d_i     (tap_in),
      .q_o     (taps[k])
    );
  end

  // Add the new sample, drop the oldest one leaving the chain
  assign sum_wide = {1'b0, sum_q}
                  + (wec_pkg::SumBits + 1)'(sample_i)
                  - (wec_pkg::SumBits + 1)'(taps[wec_pkg::WindowDepth-1]);

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.load) begin
      sum_d = sum_wide[wec_pkg::SumBits-1:0];
    end
  end

  assign sum_cmp = wec_pkg::cmp_t'(sum_d);

  // Classify with hysteresis; light wins when both limits are crossed
  always_comb begin
    area_cls = area_q;
    if (sum_cmp >= limits_i.upper_lim) begin
      area_cls = wec_pkg::AreaDark;
    end
    if (sum_cmp < limits_i.lower_lim) begin
      area_cls = wec_pkg::AreaLight;
    end
  end

  // Count class changes, zero on clear
  always_comb begin
    count_d = count_q;
    area_d  = area_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.load) begin
      area_d = area_cls;
      if (area_cls != area_q) begin
        count_d = count_q + wec_pkg::count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      area_q  <= wec_pkg::AreaDark;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      area_q  <= area_d;
    end
  end

  assign count_nxt_o = count_d;
  assign area_nxt_o  = area_d;

endmodule
